// ----- rtl/bsfb_pkg.sv -----
package bsfb_pkg;

    // Default number of trailing check bytes removed from each command.
    localparam int DROPPED_TAIL_DEF = 2;

    // Frame marks and escaping.
    localparam logic [7:0] MARK_OPEN  = 8'hC0;
    localparam logic [7:0] MARK_CLOSE = 8'hC1;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] ESC_FLIP   = 8'h20;

    // Reflected CRC-16, X.25 style.
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_SOURCE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_TARGET_ADDRESS = 2'd1;
    localparam logic [1:0] CFG_PACKET_OPCODE  = 2'd2;
    localparam logic [1:0] CFG_SEQUENCE_VALUE = 2'd3;

    // Register reset values.
    localparam logic [7:0] RST_SOURCE_ADDRESS = 8'hFE;
    localparam logic [7:0] RST_TARGET_ADDRESS = 8'h00;
    localparam logic [7:0] RST_PACKET_OPCODE  = 8'h06;
    localparam logic [7:0] RST_SEQUENCE_VALUE = 8'h00;

    // Folds one byte into the running CRC, least significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/byte_stuffed_frame_builder_crc16_top.sv -----
// Byte-stuffed frame builder with CRC-16.
// Input channel (i_in_valid / o_in_ready) takes one command byte per word, with
// i_is_last on the final byte. Output channel (o_out_valid / i_out_ready) gives
// one word per cycle while the receiver takes them: the escaped frame stream,
// o_frame_end high on the closing 0xC1. Each frame is 0xC0, four header bytes
// from the configuration registers, the command bytes less the trailing
// DROPPED_TAIL check bytes, the CRC (low byte first) and 0xC1; header, payload
// and CRC bytes are escaped. A word is first held in a job register (the list of
// frame pieces it causes) and the emitter then loads one output word per cycle,
// while the receiver is not stalling, into the output register. A word's job gives
// one output word for a plain payload byte, two for an escaped one, up to nine
// when a frame opens or closes; words that produce nothing leave the job register
// empty. A new word is accepted while the job register is empty or in the cycle
// the previous job hands over its last output word.
// Reset (synchronous, active low) closes any open frame, empties the job and
// output registers and reloads the header registers with their defaults.
// When the receiver stalls, the output register holds its word and the emitter
// and then the input channel stall behind it; nothing is lost.
module byte_stuffed_frame_builder_crc16_top
    import bsfb_pkg::*;
#(
    parameter int DROPPED_TAIL = DROPPED_TAIL_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_is_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_frame_end
);

    localparam int HOLD_DEPTH = (DROPPED_TAIL > 0) ? DROPPED_TAIL : 1;
    localparam int FW = $clog2(HOLD_DEPTH + 1);
    localparam int CW = $clog2(HOLD_DEPTH + 2);

    // Frame piece codes; each is also its bit in the job mask.
    localparam int NPH = 10;
    localparam logic [3:0] PH_OPEN  = 4'd0;
    localparam logic [3:0] PH_HDR0  = 4'd1;
    localparam logic [3:0] PH_HDR1  = 4'd2;
    localparam logic [3:0] PH_HDR2  = 4'd3;
    localparam logic [3:0] PH_HDR3  = 4'd4;
    localparam logic [3:0] PH_POP0  = 4'd5;
    localparam logic [3:0] PH_POP1  = 4'd6;
    localparam logic [3:0] PH_CRCL  = 4'd7;
    localparam logic [3:0] PH_CRCH  = 4'd8;
    localparam logic [3:0] PH_CLOSE = 4'd9;

    typedef logic [NPH-1:0] t_mask;

    // Registers.
    logic [7:0]  r_src, n_src, r_tgt, n_tgt, r_opc, n_opc, r_seq, n_seq;
    logic [7:0]  r_hold [HOLD_DEPTH];
    logic [7:0]  n_hold [HOLD_DEPTH];
    logic [FW-1:0] r_fill, n_fill;
    logic        r_inside, n_inside;
    t_mask       r_job_mask, n_job_mask;
    logic [7:0]  r_pop0, n_pop0, r_pop1, n_pop1;
    logic        r_esc_half, n_esc_half;
    logic [15:0] r_crc, n_crc;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_end, n_out_end;

    // Working signals.
    logic          in_fire;
    logic          ignore_word;
    logic [FW-1:0] eff_fill;
    logic [CW-1:0] cnt;
    logic [7:0]    q [HOLD_DEPTH + 1];
    logic          pop_one;
    logic [CW-1:0] npop_last;
    t_mask         new_mask;
    logic [3:0]    cur_phase;
    t_mask         cur_bit;
    logic [7:0]    cur_val;
    logic          need_esc;
    logic          is_data;
    logic          emit_go;
    logic          piece_done;
    logic          job_done;
    logic [15:0]   crc_out;

    assign crc_out = r_crc ^ CRC_XOROUT;

    // Configuration registers.
    always_comb begin
        n_src = r_src;
        n_tgt = r_tgt;
        n_opc = r_opc;
        n_seq = r_seq;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SOURCE_ADDRESS: n_src = i_cfg_data;
                CFG_TARGET_ADDRESS: n_tgt = i_cfg_data;
                CFG_PACKET_OPCODE:  n_opc = i_cfg_data;
                CFG_SEQUENCE_VALUE: n_seq = i_cfg_data;
                default: ;
            endcase
        end
    end

    // Emitter: picks the lowest pending piece of the job and forms its byte.
    always_comb begin
        cur_phase = PH_OPEN;
        for (int k = NPH - 1; k >= 0; k--) begin
            if (r_job_mask[k]) begin
                cur_phase = 4'(k);
            end
        end
        cur_bit = t_mask'(1) << cur_phase;

        case (cur_phase)
            PH_OPEN:  cur_val = MARK_OPEN;
            PH_HDR0:  cur_val = r_src;
            PH_HDR1:  cur_val = r_tgt;
            PH_HDR2:  cur_val = r_opc;
            PH_HDR3:  cur_val = r_seq;
            PH_POP0:  cur_val = r_pop0;
            PH_POP1:  cur_val = r_pop1;
            PH_CRCL:  cur_val = crc_out[7:0];
            PH_CRCH:  cur_val = crc_out[15:8];
            PH_CLOSE: cur_val = MARK_CLOSE;
            default:  cur_val = MARK_CLOSE;
        endcase

        is_data  = cur_phase inside {[PH_HDR0:PH_POP1]};
        need_esc = (cur_phase inside {[PH_HDR0:PH_CRCH]}) &&
                   (cur_val inside {ESC_BYTE, MARK_OPEN, MARK_CLOSE});

        emit_go    = (r_job_mask != '0) && (!r_out_valid || i_out_ready);
        piece_done = emit_go && !(need_esc && !r_esc_half);
        job_done   = piece_done && ((r_job_mask & ~cur_bit) == '0);
    end

    assign o_in_ready = (r_job_mask == '0) || job_done;
    assign in_fire    = i_in_valid && o_in_ready;

    // Input side: hold-back queue and the job that this word causes.
    always_comb begin
        ignore_word = !r_inside && i_is_last;
        eff_fill    = r_inside ? r_fill : '0;
        cnt         = CW'(eff_fill) + CW'(1);

        for (int k = 0; k < HOLD_DEPTH; k++) begin
            q[k] = (FW'(k) < eff_fill) ? r_hold[k] : i_data_byte;
        end
        q[HOLD_DEPTH] = i_data_byte;

        pop_one   = cnt > CW'(HOLD_DEPTH);
        npop_last = (cnt > CW'(DROPPED_TAIL)) ? (cnt - CW'(DROPPED_TAIL)) : '0;

        new_mask = '0;
        if (!r_inside) begin
            new_mask[PH_OPEN] = 1'b1;
            new_mask[PH_HDR0] = 1'b1;
            new_mask[PH_HDR1] = 1'b1;
            new_mask[PH_HDR2] = 1'b1;
            new_mask[PH_HDR3] = 1'b1;
        end
        if (i_is_last) begin
            new_mask[PH_POP0]  = npop_last >= CW'(1);
            new_mask[PH_POP1]  = npop_last >= CW'(2);
            new_mask[PH_CRCL]  = 1'b1;
            new_mask[PH_CRCH]  = 1'b1;
            new_mask[PH_CLOSE] = 1'b1;
        end else begin
            new_mask[PH_POP0] = pop_one;
        end
        if (ignore_word) begin
            new_mask = '0;
        end

        // Queue update.
        n_fill   = r_fill;
        n_inside = r_inside;
        for (int k = 0; k < HOLD_DEPTH; k++) begin
            n_hold[k] = r_hold[k];
        end
        if (in_fire && !ignore_word) begin
            if (i_is_last) begin
                n_fill   = '0;
                n_inside = 1'b0;
            end else begin
                n_inside = 1'b1;
                n_fill   = FW'(cnt - CW'(pop_one));
                for (int k = 0; k < HOLD_DEPTH; k++) begin
                    n_hold[k] = pop_one ? q[k + 1] : q[k];
                end
            end
        end
    end

    // Job register and emitter state.
    always_comb begin
        n_job_mask = r_job_mask;
        n_pop0     = r_pop0;
        n_pop1     = r_pop1;
        n_esc_half = r_esc_half;
        n_crc      = r_crc;
        n_out_byte = r_out_byte;
        n_out_end  = r_out_end;
        n_out_valid = r_out_valid && !i_out_ready;

        if (emit_go) begin
            n_out_valid = 1'b1;
            n_out_end   = (cur_phase == PH_CLOSE);
            if (need_esc && !r_esc_half) begin
                n_out_byte = ESC_BYTE;
                n_esc_half = 1'b1;
            end else begin
                n_out_byte = need_esc ? (cur_val ^ ESC_FLIP) : cur_val;
                n_esc_half = 1'b0;
                n_job_mask = r_job_mask & ~cur_bit;
                if (cur_phase == PH_OPEN) begin
                    n_crc = CRC_INIT;
                end else if (is_data) begin
                    n_crc = crc_byte(r_crc, cur_val);
                end
            end
        end

        if (in_fire) begin
            n_job_mask = new_mask;
            n_pop0     = q[0];
            n_pop1     = q[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src       <= RST_SOURCE_ADDRESS;
            r_tgt       <= RST_TARGET_ADDRESS;
            r_opc       <= RST_PACKET_OPCODE;
            r_seq       <= RST_SEQUENCE_VALUE;
            r_fill      <= '0;
            r_inside    <= 1'b0;
            r_job_mask  <= '0;
            r_esc_half  <= 1'b0;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_src       <= n_src;
            r_tgt       <= n_tgt;
            r_opc       <= n_opc;
            r_seq       <= n_seq;
            r_fill      <= n_fill;
            r_inside    <= n_inside;
            r_job_mask  <= n_job_mask;
            r_esc_half  <= n_esc_half;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < HOLD_DEPTH; k++) begin
            r_hold[k] <= n_hold[k];
        end
        r_pop0     <= n_pop0;
        r_pop1     <= n_pop1;
        r_out_byte <= n_out_byte;
        r_out_end  <= n_out_end;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_frame_end = r_out_end;

    // An escape prefix already sent means its piece is still pending.
    a_esc_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc_half |-> (r_job_mask != '0))
        else $error("escape half pending without a job");

    // The closing mark is the only word flagged as frame end.
    a_end_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> (o_out_byte == MARK_CLOSE))
        else $error("frame end on a byte other than the closing mark");

    // No bytes are held back outside a frame.
    a_fill_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_inside |-> (r_fill == '0))
        else $error("held bytes outside a frame");

    // The queue never holds more than the hold-back depth.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(HOLD_DEPTH))
        else $error("hold-back queue overfilled");

    // An opening mark still pending always has the full header behind it.
    a_open_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_mask[PH_OPEN] |-> (r_job_mask[PH_HDR0] && r_job_mask[PH_HDR1] &&
                                 r_job_mask[PH_HDR2] && r_job_mask[PH_HDR3]))
        else $error("header pieces lost from an opening job");

    // Output word is held while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_byte)))
        else $error("output word changed while stalled");

endmodule

// ----- tb/testbench.sv -----
module testbench;
    import bsfb_pkg::*;

    localparam int TAIL          = DROPPED_TAIL_DEF;
    localparam int HOLD          = (TAIL > 0) ? TAIL : 1;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [7:0] value;
        logic       is_end;
    } t_frame_word;

    // Clock, reset and the block's inputs, all known from time zero.
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_index = CFG_SOURCE_ADDRESS;
    logic [7:0] i_cfg_data  = 8'h00;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_is_last   = 1'b0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_frame_end;

    // Predictor state: header registers, held-back bytes and the running CRC.
    logic [7:0]  header_reg [4];
    logic [7:0]  held_bytes [HOLD + 1];
    int          held_count;
    logic [15:0] crc_acc;
    bit          frame_open;
    t_frame_word frame_bytes_due [$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int unsigned rx_hold_req    = 0;
    int unsigned rx_hold_left   = 0;

    always #1 i_clk = ~i_clk;

    byte_stuffed_frame_builder_crc16_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_is_last   (i_is_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end)
    );

    // Reflected CRC-16, one data bit at a time.
    function automatic logic [15:0] fold_crc(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r  = r >> 1;
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic void due_raw(input logic [7:0] b, input logic is_end);
        t_frame_word w;
        w.value  = b;
        w.is_end = is_end;
        frame_bytes_due.push_back(w);
    endfunction

    // Bytes that collide with the marks or the escape go out as escape plus flipped byte.
    function automatic void due_escaped(input logic [7:0] b);
        if (b == ESC_BYTE || b == MARK_OPEN || b == MARK_CLOSE) begin
            due_raw(ESC_BYTE, 1'b0);
            due_raw(b ^ ESC_FLIP, 1'b0);
        end else begin
            due_raw(b, 1'b0);
        end
    endfunction

    function automatic void due_covered(input logic [7:0] b);
        crc_acc = fold_crc(crc_acc, b);
        due_escaped(b);
    endfunction

    function automatic void release_oldest_held();
        logic [7:0] b;
        b = held_bytes[0];
        for (int i = 0; i < HOLD; i++) begin
            held_bytes[i] = held_bytes[i + 1];
        end
        held_bytes[HOLD] = 8'h00;
        held_count--;
        due_covered(b);
    endfunction

    function automatic void reset_frame_model();
        header_reg[CFG_SOURCE_ADDRESS] = RST_SOURCE_ADDRESS;
        header_reg[CFG_TARGET_ADDRESS] = RST_TARGET_ADDRESS;
        header_reg[CFG_PACKET_OPCODE]  = RST_PACKET_OPCODE;
        header_reg[CFG_SEQUENCE_VALUE] = RST_SEQUENCE_VALUE;
        for (int i = 0; i <= HOLD; i++) begin
            held_bytes[i] = 8'h00;
        end
        held_count = 0;
        crc_acc    = CRC_INIT;
        frame_open = 1'b0;
    endfunction

    // Works out the frame words that one accepted command byte causes.
    function automatic void predict_frame_bytes(input logic [7:0] b, input logic is_last_byte);
        logic [15:0] fcs;
        if (!frame_open) begin
            // A lone last byte cannot open a frame and is dropped silently.
            if (is_last_byte) begin
                return;
            end
            frame_open = 1'b1;
            held_count = 0;
            crc_acc    = CRC_INIT;
            due_raw(MARK_OPEN, 1'b0);
            due_covered(header_reg[CFG_SOURCE_ADDRESS]);
            due_covered(header_reg[CFG_TARGET_ADDRESS]);
            due_covered(header_reg[CFG_PACKET_OPCODE]);
            due_covered(header_reg[CFG_SEQUENCE_VALUE]);
        end
        if (held_count < HOLD + 1) begin
            held_bytes[held_count] = b;
            held_count++;
        end
        if (!is_last_byte) begin
            while (held_count > HOLD) begin
                release_oldest_held();
            end
        end else begin
            // The trailing check bytes stay behind; then the new CRC and the close mark.
            while (held_count > TAIL) begin
                release_oldest_held();
            end
            fcs = crc_acc ^ CRC_XOROUT;
            due_escaped(fcs[7:0]);
            due_escaped(fcs[15:8]);
            due_raw(MARK_CLOSE, 1'b1);
            for (int i = 0; i <= HOLD; i++) begin
                held_bytes[i] = 8'h00;
            end
            held_count = 0;
            crc_acc    = CRC_INIT;
            frame_open = 1'b0;
        end
    endfunction

    // Watches both channels: predicts on each accepted input word, checks each output word.
    always @(posedge i_clk) begin : watch_channels
        t_frame_word due;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_frame_bytes(i_data_byte, i_is_last);
            end
            if (o_out_valid && i_out_ready) begin
                if (frame_bytes_due.size() == 0) begin
                    $error("unexpected word: out_byte 0x%02h frame_end %0b",
                           o_out_byte, o_frame_end);
                    mismatch_count++;
                end else begin
                    due = frame_bytes_due.pop_front();
                    if (o_out_byte !== due.value) begin
                        $error("out_byte: expected 0x%02h, got 0x%02h", due.value, o_out_byte);
                        mismatch_count++;
                    end
                    if (o_frame_end !== due.is_end) begin
                        $error("frame_end: expected %0b, got %0b", due.is_end, o_frame_end);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req != 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offers one command byte and returns at the edge where it is taken.
    // Valid is only lowered when a gap follows, so back-to-back words stay valid.
    task automatic send_word(input logic [7:0] b, input logic is_last_byte);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_is_last   <= is_last_byte;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    // Sends a whole command; the final byte carries the last mark.
    task automatic send_command(input logic [7:0] bytes [$]);
        for (int i = 0; i < bytes.size(); i++) begin
            send_word(bytes[i], i == bytes.size() - 1);
        end
    endtask

    // Lets every expected word arrive, then gives the block time to finish held work.
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (frame_bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        header_reg[idx] = val;
    endtask

    // Writes all four header registers on consecutive edges.
    task automatic load_header(input logic [7:0] src, input logic [7:0] tgt,
                               input logic [7:0] opc, input logic [7:0] seq);
        write_cfg(CFG_SOURCE_ADDRESS, src);
        write_cfg(CFG_TARGET_ADDRESS, tgt);
        write_cfg(CFG_PACKET_OPCODE, opc);
        write_cfg(CFG_SEQUENCE_VALUE, seq);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Default header, with payload bytes at both extremes and all three escaped values.
    task automatic test_default_header_and_escapes();
        send_command('{8'h00, 8'hFF, ESC_BYTE, MARK_OPEN, MARK_CLOSE, 8'h55, 8'hAA});
        settle_idle();
    endtask

    // A lone byte marked last is ignored; two bytes give an empty payload; three give one.
    task automatic test_short_commands();
        send_command('{8'h5A});
        settle_idle();
        send_command('{8'h12, 8'h34});
        send_command('{8'h80, 8'h01, 8'h7F});
        settle_idle();
    endtask

    // Header registers at their extremes, including values that need escaping.
    task automatic test_header_extremes();
        load_header(MARK_OPEN, MARK_CLOSE, ESC_BYTE, 8'hFF);
        send_command('{8'h01, 8'h02});
        settle_idle();
        load_header(8'h00, 8'h00, 8'h00, 8'h00);
        send_command('{8'hFE, 8'hEF});
        settle_idle();
    endtask

    // A header write while a frame is open only shows in the following frame.
    task automatic test_write_inside_frame();
        send_word(8'h11, 1'b0);
        send_word(8'h22, 1'b0);
        settle_idle();
        load_header(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(8'h33, 1'b0);
        send_word(8'h44, 1'b0);
        send_word(8'h55, 1'b1);
        send_command('{8'h66, 8'h77});
        settle_idle();
    endtask

    // Random commands, mostly of ordinary length, now and then lone bytes or long ones.
    task automatic run_random_commands(input int unsigned word_budget);
        int unsigned taken;
        int unsigned len;
        int unsigned r;
        logic [7:0]  b;
        taken = 0;
        while (taken < word_budget) begin
            r = $urandom_range(99);
            if (r < 8) begin
                len = 1;
            end else if (r < 20) begin
                len = $urandom_range(3, 2);
            end else if (r < 95) begin
                len = $urandom_range(12, 4);
            end else begin
                len = $urandom_range(40, 20);
            end
            for (int unsigned k = 1; k <= len; k++) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    b = ESC_BYTE;
                end else if (r < 16) begin
                    b = MARK_OPEN;
                end else if (r < 24) begin
                    b = MARK_CLOSE;
                end else begin
                    b = 8'($urandom_range(255));
                end
                send_word(b, k == len);
            end
            if (len > 1) begin
                taken += len;
            end
        end
        settle_idle();
    endtask

    task automatic test_random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input int unsigned word_budget);
        send_idle_pct = tx_pct;
        recv_idle_pct = rx_pct;
        load_header(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)));
        run_random_commands(word_budget);
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering words.
    task automatic test_output_backpressure();
        logic [7:0] bytes [$];
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 24; i++) begin
            bytes.push_back(8'($urandom_range(255)));
        end
        rx_hold_req = 300;
        send_command(bytes);
        settle_idle();
    endtask

    initial begin
        reset_frame_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 27;
        recv_idle_pct = 58;
        test_default_header_and_escapes();
        test_short_commands();
        test_header_extremes();
        test_write_inside_frame();

        test_random_phase(27, 58, 55);
        test_random_phase(58, 27, 55);
        test_random_phase(0, 0, 50);
        test_output_backpressure();

        if (mismatch_count == 0 && frame_bytes_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/bsfb_pkg.sv
rtl/byte_stuffed_frame_builder_crc16_top.sv
tb/testbench.sv
